// File: design/raft_election_node_defines.svh
// Assertion macros used by the back end (ren_back) of the election node.
`ifndef RAFT_ELECTION_NODE_DEFINES_SVH
`define RAFT_ELECTION_NODE_DEFINES_SVH
`ifndef SYNTHESIS
`define REN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define REN_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define REN_ASSERT(lbl, prop, msg)
`define REN_NEVER(lbl, cond, msg)
`endif
`endif

// File: design/ren_pkg.sv
package ren_pkg;

  localparam int LOG_DEPTH_DEF = 1024;
  localparam int TERM_BITS_DEF = 32;

  localparam logic [7:0]  RST_PEER_COUNT  = 8'd4;
  localparam logic [15:0] RST_TIMEOUT_MIN = 16'd500;
  localparam logic [15:0] RST_TIMEOUT_MSK = 16'd511;
  localparam logic [15:0] RST_HB_PERIOD   = 16'd50;
  localparam logic [15:0] LFSR_SEED       = 16'hACE1;

  localparam int CFG_AW = 5;

  typedef enum logic [2:0] {
    REG_NODE_ID   = 3'd0,
    REG_PEER_CNT  = 3'd1,
    REG_TMO_MIN   = 3'd2,
    REG_TMO_MASK  = 3'd3,
    REG_HB_PERIOD = 3'd4,
    REG_COMMIT    = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_APPEND_REQ = 3'd1,
    OP_VOTE_REQ   = 3'd2,
    OP_VOTE_REPLY = 3'd3,
    OP_LOCAL_APP  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ROLE_FOLLOWER  = 2'd0,
    ROLE_CANDIDATE = 2'd1,
    ROLE_LEADER    = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    KIND_APPEND_REPLY = 2'd0,
    KIND_VOTE_REPLY   = 2'd1,
    KIND_VOTE_REQ     = 2'd2,
    KIND_HEARTBEAT    = 2'd3
  } kind_t;

  typedef enum logic {
    BK_RUN,
    BK_LOOKUP
  } bk_state_t;

  typedef struct packed {
    logic [7:0]  node_id;
    logic [7:0]  peer_count;
    logic [15:0] timeout_min;
    logic [15:0] timeout_mask;
    logic [15:0] hb_period;
    logic [10:0] commit_index;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] msg_term;
    logic [7:0]  sender_id;
    logic [15:0] msg_log_index;
    logic [31:0] msg_log_term;
    logic        vote_granted;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    kind_t       out_kind;
    logic [31:0] out_term;
    logic        success;
    logic [10:0] own_log_length;
    logic [31:0] own_last_term;
    logic [10:0] out_commit;
    role_t       role_now;
    logic        log_full;
  } result_t;

endpackage

// File: design/ren_ifs.sv
interface ren_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] msg_term;
  logic [7:0]  sender_id;
  logic [15:0] msg_log_index;
  logic [31:0] msg_log_term;
  logic        vote_granted;
  modport source (output valid, req_type, msg_term, sender_id, msg_log_index,
                  msg_log_term, vote_granted, input ready);
  modport sink (input valid, req_type, msg_term, sender_id, msg_log_index,
                msg_log_term, vote_granted, output ready);
endinterface

interface ren_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [31:0] out_term;
  logic        success;
  logic [10:0] own_log_length;
  logic [31:0] own_last_term;
  logic [10:0] out_commit;
  logic [1:0]  role_now;
  logic        log_full;
  modport source (output valid, out_kind, out_term, success, own_log_length,
                  own_last_term, out_commit, role_now, log_full, input ready);
  modport sink (input valid, out_kind, out_term, success, own_log_length,
                own_last_term, out_commit, role_now, log_full, output ready);
endinterface

// File: design/ren_front.sv
module ren_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ren_pkg::item_t      in_item,
  input  logic                in_known,
  output ren_pkg::queue_head_t head,
  input  logic                pop
);
  import ren_pkg::*;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready && in_known;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: design/ren_back.sv
`include "raft_election_node_defines.svh"
module ren_back #(
  parameter int LOG_DEPTH = ren_pkg::LOG_DEPTH_DEF,
  parameter int TERM_BITS = ren_pkg::TERM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ren_pkg::cfg_t        cfg,
  input  ren_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ren_pkg::result_t     out_res
);
  import ren_pkg::*;

  localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LW = $clog2(LOG_DEPTH + 1);
  localparam int TW = (TERM_BITS > 32) ? TERM_BITS : 32;
  localparam logic [TERM_BITS-1:0] TMAX = '1;

  function automatic logic [TERM_BITS-1:0] clamp(input logic [31:0] raw);
    logic [TW-1:0] w;
    w = TW'(raw);
    return (w > TW'(TMAX)) ? TMAX : TERM_BITS'(w);
  endfunction

  bk_state_t st_r, st_nxt;
  item_t     hold_r;
  logic [TERM_BITS-1:0] mem [LOG_DEPTH];
  logic [TERM_BITS-1:0] mem_q_r;

  role_t               role_r, role_nxt;
  logic [TERM_BITS-1:0] term_r, term_nxt;
  logic                vv_r, vv_nxt;
  logic [7:0]          voted_r, voted_nxt;
  logic [7:0]          lead_r, lead_nxt;
  logic                lv_r, lv_nxt;
  logic [7:0]          vc_r, vc_nxt;
  logic [15:0]         et_r, et_nxt;
  logic [15:0]         tmo_r, tmo_nxt;
  logic [15:0]         hb_r, hb_nxt;
  logic [15:0]         lfsr_r, lfsr_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic [TERM_BITS-1:0] last_r, last_nxt;
  logic                full_r, full_nxt;
  logic                out_valid_r;
  result_t             out_r;

  logic                out_free, exec, emit, ok, wr_en, rd_en;
  kind_t               kind;
  logic [10:0]         commit;
  item_t               cur;
  logic [TERM_BITS-1:0] t, lt;
  logic [15:0]         tick_t;
  logic [16:0]         tsum;
  logic [8:0]          need;

  assign out_free  = !out_valid_r || out_ready;
  assign pop       = (st_r == BK_RUN) && head.valid && out_free;
  assign cur       = (st_r == BK_LOOKUP) ? hold_r : head.item;
  assign exec      = (pop && head.item.op != OP_APPEND_REQ) ||
                     ((st_r == BK_LOOKUP) && out_free);
  assign rd_en     = pop && (head.item.op == OP_APPEND_REQ);
  assign t         = clamp(cur.msg_term);
  assign lt        = clamp(cur.msg_log_term);
  assign need      = 9'(({1'b0, cfg.peer_count} + 9'd1) >> 1) + 9'd1;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_RUN:    if (rd_en) st_nxt = BK_LOOKUP;
      BK_LOOKUP: if (out_free) st_nxt = BK_RUN;
      default:   st_nxt = BK_RUN;
    endcase
  end

  always_comb begin
    role_nxt = role_r;  term_nxt = term_r;  vv_nxt = vv_r;  voted_nxt = voted_r;
    lead_nxt = lead_r;  lv_nxt = lv_r;  vc_nxt = vc_r;  et_nxt = et_r;
    tmo_nxt = tmo_r;  hb_nxt = hb_r;  lfsr_nxt = lfsr_r;  len_nxt = len_r;
    last_nxt = last_r;  full_nxt = full_r;
    emit = 1'b0;  ok = 1'b0;  kind = KIND_APPEND_REPLY;  commit = 11'd0;
    wr_en = 1'b0;  tick_t = 16'd0;  tsum = 17'd0;
    if (exec) begin
      case (cur.op)
        OP_TICK: begin
          if (role_r == ROLE_LEADER) begin
            if (hb_r == 16'd0) begin
              hb_nxt = (cfg.hb_period == 16'd0) ? 16'd0
                                                : cfg.hb_period - 16'd1;
              emit   = 1'b1;
              kind   = KIND_HEARTBEAT;
              commit = cfg.commit_index;
            end else begin
              hb_nxt = hb_r - 16'd1;
            end
          end else begin
            tick_t = (et_r == 16'hFFFF) ? et_r : et_r + 16'd1;
            et_nxt = tick_t;
            if (tick_t >= tmo_r) begin
              term_nxt  = (term_r != TMAX) ? term_r + 1'b1 : term_r;
              role_nxt  = ROLE_CANDIDATE;
              vv_nxt    = 1'b1;
              voted_nxt = cfg.node_id;
              vc_nxt    = 8'd1;
              lv_nxt    = 1'b0;
              lfsr_nxt  = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};
              tsum      = {1'b0, cfg.timeout_min} + {1'b0, lfsr_nxt & cfg.timeout_mask};
              tmo_nxt   = tsum[16] ? 16'hFFFF : tsum[15:0];
              et_nxt    = 16'd0;
              if (9'd1 >= need) begin
                role_nxt = ROLE_LEADER;
                lead_nxt = cfg.node_id;
                lv_nxt   = 1'b1;
                hb_nxt   = 16'd0;
              end
              emit = 1'b1;
              kind = KIND_VOTE_REQ;
            end
          end
        end
        OP_APPEND_REQ: begin
          emit = 1'b1;
          kind = KIND_APPEND_REPLY;
          if (t >= term_r) begin
            if (t > term_r) begin
              term_nxt = t;
              vv_nxt   = 1'b0;
            end
            role_nxt = ROLE_FOLLOWER;
            vc_nxt   = 8'd0;
            lead_nxt = cur.sender_id;
            lv_nxt   = 1'b1;
            et_nxt   = 16'd0;
            ok = (cur.msg_log_index == 16'd0) ||
                 ((32'(cur.msg_log_index) <= 32'(len_r)) && (mem_q_r == lt));
          end
        end
        OP_VOTE_REQ: begin
          emit = 1'b1;
          kind = KIND_VOTE_REPLY;
          if (t >= term_r) begin
            if (t > term_r) begin
              term_nxt = t;
              vv_nxt   = 1'b0;
              role_nxt = ROLE_FOLLOWER;
              lv_nxt   = 1'b0;
              vc_nxt   = 8'd0;
            end
            ok = (!vv_nxt || voted_r == cur.sender_id) &&
                 ((lt > last_r) ||
                  ((lt == last_r) && (32'(cur.msg_log_index) >= 32'(len_r))));
            if (ok) begin
              vv_nxt    = 1'b1;
              voted_nxt = cur.sender_id;
              et_nxt    = 16'd0;
            end
          end
        end
        OP_VOTE_REPLY: begin
          if (t > term_r) begin
            term_nxt = t;
            vv_nxt   = 1'b0;
            role_nxt = ROLE_FOLLOWER;
            lv_nxt   = 1'b0;
            vc_nxt   = 8'd0;
          end else if (role_r == ROLE_CANDIDATE && t == term_r && cur.vote_granted) begin
            vc_nxt = (vc_r != 8'hFF) ? vc_r + 8'd1 : vc_r;
            if ({1'b0, vc_nxt} >= need) begin
              role_nxt = ROLE_LEADER;
              lead_nxt = cfg.node_id;
              lv_nxt   = 1'b1;
              hb_nxt   = 16'd0;
            end
          end
        end
        OP_LOCAL_APP: begin
          if (32'(len_r) < LOG_DEPTH) begin
            wr_en    = 1'b1;
            last_nxt = t;
            len_nxt  = len_r + 1'b1;
          end else begin
            full_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[len_r[AW-1:0]] <= t;
    end
    if (rd_en) begin
      mem_q_r <= mem[AW'(head.item.msg_log_index - 16'd1)];
      hold_r  <= head.item;
    end
    if (emit) begin
      out_r.out_kind       <= kind;
      out_r.out_term       <= 32'(term_nxt);
      out_r.success        <= ok;
      out_r.own_log_length <= 11'(len_nxt);
      out_r.own_last_term  <= 32'(last_nxt);
      out_r.out_commit     <= commit;
      out_r.role_now       <= role_nxt;
      out_r.log_full       <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_RUN;  role_r <= ROLE_FOLLOWER;  term_r <= '0;  vv_r <= 1'b0;
      voted_r <= 8'd0;  lead_r <= 8'd0;  lv_r <= 1'b0;  vc_r <= 8'd0;
      et_r <= 16'd0;  tmo_r <= RST_TIMEOUT_MIN;  hb_r <= 16'd0;
      lfsr_r <= LFSR_SEED;  len_r <= '0;  last_r <= '0;  full_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;  role_r <= role_nxt;  term_r <= term_nxt;  vv_r <= vv_nxt;
      voted_r <= voted_nxt;  lead_r <= lead_nxt;  lv_r <= lv_nxt;  vc_r <= vc_nxt;
      et_r <= et_nxt;  tmo_r <= tmo_nxt;  hb_r <= hb_nxt;  lfsr_r <= lfsr_nxt;
      len_r <= len_nxt;  last_r <= last_nxt;  full_r <= full_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `REN_NEVER(a_leader_known, role_r == ROLE_LEADER && !lv_r, "leader without leader id")
  `REN_NEVER(a_cand_voted, role_r == ROLE_CANDIDATE && !vv_r, "candidate without own vote")
  `REN_NEVER(a_len_bound, 32'(len_r) > LOG_DEPTH, "log length past capacity")
  `REN_ASSERT(a_lookup_reply, (st_r == BK_LOOKUP && out_free) |=> out_valid_r, "append reply lost")
endmodule

// File: design/raft_election_node.sv
// Channel  | Direction | Handshake     | Word
// in_ch    | input     | valid / ready | one request, tick or local append
// out_ch   | output    | valid / ready | one reply or broadcast
// cfg_*    | input     | APB write/rd  | six configuration registers
// A tick, vote request, vote reply or local append is handled in the back end once the result register is free.
// An append request first reads the log-term memory (BK_LOOKUP), then replies once the result register is free.
// A two-word queue lets the input keep accepting while the result register waits.
// Reset is synchronous and active low; the log-term memory is not cleared.
// Request types five to seven are accepted and dropped with no result.
module raft_election_node #(
  parameter int LOG_DEPTH = ren_pkg::LOG_DEPTH_DEF,
  parameter int TERM_BITS = ren_pkg::TERM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ren_in_if.sink                     in_ch,
  ren_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ren_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import ren_pkg::*;

  cfg_t        cfg_r;
  item_t       in_item;
  logic        in_known;
  queue_head_t head;
  logic        pop;
  result_t     res;
  logic        wr;
  reg_idx_t    ridx;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id      <= 8'd0;
      cfg_r.peer_count   <= RST_PEER_COUNT;
      cfg_r.timeout_min  <= RST_TIMEOUT_MIN;
      cfg_r.timeout_mask <= RST_TIMEOUT_MSK;
      cfg_r.hb_period    <= RST_HB_PERIOD;
      cfg_r.commit_index <= 11'd0;
    end else if (wr && cfg_paddr[1:0] == 2'd0) begin
      unique case (ridx)
        REG_NODE_ID:   cfg_r.node_id      <= cfg_pwdata[7:0];
        REG_PEER_CNT:  cfg_r.peer_count   <= cfg_pwdata[7:0];
        REG_TMO_MIN:   cfg_r.timeout_min  <= cfg_pwdata[15:0];
        REG_TMO_MASK:  cfg_r.timeout_mask <= cfg_pwdata[15:0];
        REG_HB_PERIOD: cfg_r.hb_period    <= cfg_pwdata[15:0];
        REG_COMMIT:    cfg_r.commit_index <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    unique case (ridx)
      REG_NODE_ID:   cfg_prdata = 32'(cfg_r.node_id);
      REG_PEER_CNT:  cfg_prdata = 32'(cfg_r.peer_count);
      REG_TMO_MIN:   cfg_prdata = 32'(cfg_r.timeout_min);
      REG_TMO_MASK:  cfg_prdata = 32'(cfg_r.timeout_mask);
      REG_HB_PERIOD: cfg_prdata = 32'(cfg_r.hb_period);
      REG_COMMIT:    cfg_prdata = 32'(cfg_r.commit_index);
      default:       cfg_prdata = 32'd0;
    endcase
  end

  assign in_known = (in_ch.req_type <= 3'(OP_LOCAL_APP));
  assign in_item.op            = op_t'(in_ch.req_type);
  assign in_item.msg_term      = in_ch.msg_term;
  assign in_item.sender_id     = in_ch.sender_id;
  assign in_item.msg_log_index = in_ch.msg_log_index;
  assign in_item.msg_log_term  = in_ch.msg_log_term;
  assign in_item.vote_granted  = in_ch.vote_granted;

  ren_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .in_known (in_known),
    .head     (head),
    .pop      (pop)
  );

  ren_back #(
    .LOG_DEPTH (LOG_DEPTH),
    .TERM_BITS (TERM_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.out_kind       = res.out_kind;
  assign out_ch.out_term       = res.out_term;
  assign out_ch.success        = res.success;
  assign out_ch.own_log_length = res.own_log_length;
  assign out_ch.own_last_term  = res.own_last_term;
  assign out_ch.out_commit     = res.out_commit;
  assign out_ch.role_now       = res.role_now;
  assign out_ch.log_full       = res.log_full;
endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ren_pkg::*;

  localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
  localparam logic [31:0] TERM_TOP     = 32'hFFFF_FFFF;
  localparam int          LOG_CAP      = 1024;
  localparam int          IDLE_LIMIT   = 4000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          FIRST_TICKS  = 600;
  localparam int          TICK_CAP     = 48;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] mterm;
    logic [7:0]  sender;
    logic [15:0] idx;
    logic [31:0] lterm;
    logic        granted;
  } msg_t;

  class ren_scoreboard;
    cfg_t        cfg;
    role_t       role;
    logic [31:0] term;
    bit          vote_valid;
    logic [7:0]  voted_for;
    logic [7:0]  lead_node;
    bit          leader_valid;
    int unsigned vote_count;
    int unsigned el_timer;
    int unsigned el_timeout;
    int unsigned hb_timer;
    logic [15:0] lfsr;
    int unsigned log_len;
    logic [31:0] last_term;
    bit          overflow;
    logic [31:0] log_terms [LOG_CAP];
    result_t     pending[$];
    int          errors;

    function new();
      cfg = '{node_id: 8'd0, peer_count: RST_PEER_COUNT, timeout_min: RST_TIMEOUT_MIN,
              timeout_mask: RST_TIMEOUT_MSK, hb_period: RST_HB_PERIOD,
              commit_index: 11'd0};
      role = ROLE_FOLLOWER;
      term = '0;
      vote_valid = 0;
      voted_for = '0;
      lead_node = '0;
      leader_valid = 0;
      vote_count = 0;
      el_timer = 0;
      el_timeout = 32'(RST_TIMEOUT_MIN);
      hb_timer = 0;
      lfsr = LFSR_SEED;
      log_len = 0;
      last_term = '0;
      overflow = 0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_NODE_ID:   cfg.node_id = v[7:0];
        REG_PEER_CNT:  cfg.peer_count = v[7:0];
        REG_TMO_MIN:   cfg.timeout_min = v[15:0];
        REG_TMO_MASK:  cfg.timeout_mask = v[15:0];
        REG_HB_PERIOD: cfg.hb_period = v[15:0];
        REG_COMMIT:    cfg.commit_index = v[10:0];
        default: ;
      endcase
    endfunction

    function void push_result(kind_t k, bit ok, logic [10:0] commit);
      result_t r;
      r.out_kind = k;
      r.out_term = term;
      r.success = ok;
      r.own_log_length = log_len[10:0];
      r.own_last_term = last_term;
      r.out_commit = commit;
      r.role_now = role;
      r.log_full = overflow;
      pending.push_back(r);
    endfunction

    function void draw_timeout();
      logic        fb;
      int unsigned sum;
      fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
      lfsr = {fb, lfsr[15:1]};
      sum = cfg.timeout_min + (lfsr & cfg.timeout_mask);
      el_timeout = (sum > 65535) ? 65535 : sum;
    endfunction

    function void step_down(logic [31:0] t);
      term = t;
      vote_valid = 0;
      role = ROLE_FOLLOWER;
      leader_valid = 0;
      vote_count = 0;
    endfunction

    function void check_majority();
      if (vote_count >= (cfg.peer_count + 1) / 2 + 1) begin
        role = ROLE_LEADER;
        lead_node = cfg.node_id;
        leader_valid = 1;
        hb_timer = 0;
      end
    endfunction

    function void note_input(msg_t m);
      bit ok;
      case (m.op)
        OP_TICK: begin
          if (role == ROLE_LEADER) begin
            if (hb_timer == 0) begin
              hb_timer = ((cfg.hb_period == 0) ? 1 : cfg.hb_period) - 1;
              push_result(KIND_HEARTBEAT, 0, cfg.commit_index);
            end else begin
              hb_timer--;
            end
          end else begin
            if (el_timer < 65535) el_timer++;
            if (el_timer >= el_timeout) begin
              if (term != TERM_TOP) term++;
              role = ROLE_CANDIDATE;
              vote_valid = 1;
              voted_for = cfg.node_id;
              vote_count = 1;
              leader_valid = 0;
              draw_timeout();
              el_timer = 0;
              check_majority();
              push_result(KIND_VOTE_REQ, 0, '0);
            end
          end
        end
        OP_APPEND_REQ: begin
          if (m.mterm < term) begin
            push_result(KIND_APPEND_REPLY, 0, '0);
          end else begin
            if (m.mterm > term) begin
              term = m.mterm;
              vote_valid = 0;
            end
            role = ROLE_FOLLOWER;
            vote_count = 0;
            lead_node = m.sender;
            leader_valid = 1;
            el_timer = 0;
            ok = (m.idx == 0) || (m.idx <= log_len && log_terms[m.idx - 1] == m.lterm);
            push_result(KIND_APPEND_REPLY, ok, '0);
          end
        end
        OP_VOTE_REQ: begin
          if (m.mterm < term) begin
            push_result(KIND_VOTE_REPLY, 0, '0);
          end else begin
            if (m.mterm > term) step_down(m.mterm);
            ok = (!vote_valid || voted_for == m.sender) &&
                 (m.lterm > last_term || (m.lterm == last_term && m.idx >= log_len));
            if (ok) begin
              vote_valid = 1;
              voted_for = m.sender;
              el_timer = 0;
            end
            push_result(KIND_VOTE_REPLY, ok, '0);
          end
        end
        OP_VOTE_REPLY: begin
          if (m.mterm > term) begin
            step_down(m.mterm);
          end else if (role == ROLE_CANDIDATE && m.mterm == term && m.granted) begin
            if (vote_count < 255) vote_count++;
            check_majority();
          end
        end
        OP_LOCAL_APP: begin
          if (log_len < LOG_CAP) begin
            log_terms[log_len] = m.mterm;
            last_term = m.mterm;
            log_len++;
          end else begin
            overflow = 1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.out_kind !== want.out_kind || got.out_term !== want.out_term ||
          got.success !== want.success || got.own_log_length !== want.own_log_length ||
          got.own_last_term !== want.own_last_term || got.out_commit !== want.out_commit ||
          got.role_now !== want.role_now || got.log_full !== want.log_full) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  ren_in_if  in_ch ();
  ren_out_if out_ch ();

  raft_election_node dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  ren_scoreboard sb = new();
  int idle_cycles = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_count = 0;
  int rx_mode = 0;
  int burst_left = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result('{out_kind: kind_t'(out_ch.out_kind), out_term: out_ch.out_term,
                          success: out_ch.success, own_log_length: out_ch.own_log_length,
                          own_last_term: out_ch.own_last_term,
                          out_commit: out_ch.out_commit,
                          role_now: role_t'(out_ch.role_now), log_full: out_ch.log_full});
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input('{op: in_ch.req_type, mterm: in_ch.msg_term, sender: in_ch.sender_id,
                        idx: in_ch.msg_log_index, lterm: in_ch.msg_log_term,
                        granted: in_ch.vote_granted});
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** raft_election_node: FAILED **");
        $finish;
      end
    end
  end

  // The receiver draws its stall pattern at random and can be told to hold off.
  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count % 64 == 0) rx_mode <= $urandom_range(3);
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(1));
        2: out_ch.ready <= ($urandom_range(7) != 0);
        default: out_ch.ready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  task automatic send_msg(msg_t m);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(4) == 0 ? 0 : $urandom_range(6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= m.op;
    in_ch.msg_term <= m.mterm;
    in_ch.sender_id <= m.sender;
    in_ch.msg_log_index <= m.idx;
    in_ch.msg_log_term <= m.lterm;
    in_ch.vote_granted <= m.granted;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(r * 4);
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(r, v);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] id, logic [7:0] peers, logic [15:0] tmin,
                            logic [15:0] tmask, logic [15:0] hb, logic [10:0] commit);
    write_reg(REG_NODE_ID, 32'(id));
    write_reg(REG_PEER_CNT, 32'(peers));
    write_reg(REG_TMO_MIN, 32'(tmin));
    write_reg(REG_TMO_MASK, 32'(tmask));
    write_reg(REG_HB_PERIOD, 32'(hb));
    write_reg(REG_COMMIT, 32'(commit));
  endtask

  function automatic msg_t mk(logic [2:0] op, logic [31:0] mterm, logic [7:0] sender,
                              logic [15:0] idx, logic [31:0] lterm, logic granted);
    msg_t m;
    m.op = op;
    m.mterm = mterm;
    m.sender = sender;
    m.idx = idx;
    m.lterm = lterm;
    m.granted = granted;
    return m;
  endfunction

  function automatic logic [31:0] near_term(logic [31:0] t);
    int d;
    d = $urandom_range(9);
    if (d < 2) return (t == 0) ? t : t - 1;
    if (d < 7) return t;
    if (d < 9) return (t == TERM_TOP) ? t : t + 1;
    return (t > TERM_TOP - 4) ? TERM_TOP : t + $urandom_range(4, 2);
  endfunction

  function automatic msg_t random_msg();
    msg_t m;
    int r;
    int unsigned k;
    r = $urandom_range(99);
    m = mk(OP_TICK, near_term(sb.term), 8'($urandom_range(255)), 16'($urandom_range(65535)),
           $urandom, 1'($urandom_range(1)));
    if (r < 35) begin
      m.op = OP_TICK;
    end else if (r < 55) begin
      m.op = OP_VOTE_REPLY;
      m.granted = ($urandom_range(4) != 0);
    end else if (r < 70) begin
      m.op = OP_APPEND_REQ;
      k = $urandom_range(9);
      if (k < 2) begin
        m.idx = '0;
      end else if (k < 9) begin
        m.idx = 16'($urandom_range(sb.log_len + 1, 1));
        if (m.idx <= sb.log_len && $urandom_range(2) != 0) m.lterm = sb.log_terms[m.idx - 1];
        else m.lterm = near_term(sb.last_term);
      end
    end else if (r < 85) begin
      m.op = OP_VOTE_REQ;
      if ($urandom_range(5) == 0) m.sender = sb.voted_for;
      if ($urandom_range(9) != 0) begin
        m.lterm = near_term(sb.last_term);
        k = $urandom_range(2);
        m.idx = 16'((k == 0 && sb.log_len > 0) ? sb.log_len - 1 : sb.log_len + k - 1);
        if (k == 0 && sb.log_len == 0) m.idx = '0;
      end
    end else if (r < 95) begin
      m.op = OP_LOCAL_APP;
      if ($urandom_range(4) == 0) m.mterm = $urandom;
    end else begin
      m.op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    end
    return m;
  endfunction

  // Ticks up to the election timeout, unless the node leads or more than max_ticks would be needed.
  task automatic run_ticks_to_election(int max_ticks);
    int n;
    if (sb.role == ROLE_LEADER) return;
    n = (sb.el_timeout > sb.el_timer) ? int'(sb.el_timeout - sb.el_timer) : 1;
    if (n > max_ticks) return;
    repeat (n) send_msg(mk(OP_TICK, '0, '0, '0, '0, 1'b0));
  endtask

  task automatic random_phase(int count, bit hold_off, bit pause);
    for (int i = 0; i < count; i++) begin
      if (hold_off && i == count / 3) hold_seq = hold_seq + 1;
      if (pause && i == count / 2) wait_drained();
      // Now and then run a well-formed election: ticks to time out, then granted votes.
      if ($urandom_range(29) == 0) begin
        run_ticks_to_election(TICK_CAP);
        repeat ($urandom_range(4, 1))
          send_msg(mk(OP_VOTE_REPLY, sb.term, 8'($urandom_range(255)),
                      16'($urandom_range(65535)), $urandom, 1'b1));
      end
      send_msg(random_msg());
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.msg_term = '0;
    in_ch.sender_id = '0;
    in_ch.msg_log_index = '0;
    in_ch.msg_log_term = '0;
    in_ch.vote_granted = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A single peer-free node: it leads right after the first timeout.
    set_config(8'd3, 8'd0, 16'd5, 16'd3, 16'd1, 11'd1024);
    send_msg(mk(OP_APPEND_REQ, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0));
    send_msg(mk(OP_VOTE_REQ, 32'd0, 8'd255, 16'hFFFF, 32'd0, 1'b1));
    send_msg(mk(OP_VOTE_REQ, 32'd0, 8'd7, 16'd0, 32'd0, 1'b0));
    send_msg(mk(OP_LOCAL_APP, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0));
    send_msg(mk(OP_LOCAL_APP, 32'd1, 8'd0, 16'd0, 32'd0, 1'b0));
    send_msg(mk(OP_APPEND_REQ, 32'd1, 8'd255, 16'd2, 32'd1, 1'b0));
    send_msg(mk(OP_APPEND_REQ, 32'd1, 8'd9, 16'd2, 32'd0, 1'b0));
    send_msg(mk(OP_APPEND_REQ, 32'd1, 8'd9, 16'hFFFF, TERM_TOP, 1'b1));
    send_msg(mk(OP_APPEND_REQ, 32'd0, 8'd9, 16'd0, 32'd0, 1'b0));
    send_msg(mk(OP_VOTE_REQ, 32'd0, 8'd9, 16'd0, 32'd0, 1'b0));
    send_msg(mk(OP_UNUSED_LO, TERM_TOP, 8'd255, 16'hFFFF, TERM_TOP, 1'b1));
    send_msg(mk(OP_UNUSED_HI, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0));
    run_ticks_to_election(FIRST_TICKS);
    send_msg(mk(OP_TICK, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0));
    send_msg(mk(OP_TICK, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0));
    send_msg(mk(OP_VOTE_REPLY, 32'd0, 8'd1, 16'd0, 32'd0, 1'b1));
    send_msg(mk(OP_VOTE_REPLY, 32'd5, 8'd1, 16'd0, 32'd0, 1'b0));
    send_msg(mk(OP_TICK, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0));
    wait_drained();

    set_config(8'd3, 8'd0, 16'd5, 16'd3, 16'd1, 11'd1024);
    random_phase(40, 1'b0, 1'b0);
    set_config(8'd255, 8'd2, 16'd1, 16'd0, 16'd4, 11'd0);
    random_phase(60, 1'b1, 1'b0);
    set_config(8'd0, 8'd4, 16'd10, 16'd15, 16'd3, 11'd7);
    random_phase(30, 1'b0, 1'b1);
    random_phase(30, 1'b0, 1'b0);
    set_config(8'd128, 8'd254, 16'd2, 16'd7, 16'd65535, 11'd513);
    random_phase(50, 1'b0, 1'b0);
    for (int p = 0; p < 2; p++) begin
      set_config(8'($urandom_range(255)), 8'($urandom_range(6, 1)),
                 16'($urandom_range(20, 1)), 16'($urandom_range(31)),
                 16'($urandom_range(8, 1)), 11'($urandom_range(1024)));
      random_phase(50, 1'b1, 1'b1);
    end
    set_config(8'($urandom_range(255)), 8'd3, 16'd65535, 16'd65535,
               16'($urandom_range(65535, 1)), 11'($urandom_range(1024)));
    random_phase(40, 1'b0, 1'b0);

    // Saturated terms, then fully random words.
    set_config(8'd77, 8'd0, 16'd1, 16'd65535, 16'd2, 11'd1024);
    send_msg(mk(OP_APPEND_REQ, TERM_TOP, 8'd255, 16'(sb.log_len),
                (sb.log_len > 0) ? sb.log_terms[sb.log_len - 1] : 32'd0, 1'b0));
    run_ticks_to_election(TICK_CAP);
    send_msg(mk(OP_TICK, 32'd0, 8'd0, 16'd0, 32'd0, 1'b0));
    send_msg(mk(OP_VOTE_REPLY, TERM_TOP, 8'd1, 16'd0, TERM_TOP, 1'b1));
    send_msg(mk(OP_VOTE_REQ, TERM_TOP, 8'd200, 16'hFFFF, TERM_TOP, 1'b1));
    repeat (40)
      send_msg(mk(3'($urandom), $urandom, 8'($urandom_range(255)),
                  16'($urandom_range(65535)), $urandom, 1'($urandom_range(1))));
    wait_drained();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** raft_election_node: PASSED **");
    end else begin
      $display("** raft_election_node: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/ren_pkg.sv
design/ren_ifs.sv
design/ren_front.sv
design/ren_back.sv
design/raft_election_node.sv
dv/testbench.sv
